// ===== rtl/core/tbcs_pkg.sv =====
// shared types and constants of the block stream checker
package tbcs_pkg;

    localparam logic [16:0] SIZE_LIMIT = 17'h10000;
    localparam logic [1:0]  HDR_LAST   = 2'd3;
    localparam logic [15:0] WORD_BYTES = 16'd4;

    typedef enum logic [1:0] {
        CFG_APPEND    = 2'd0,
        CFG_OVERWRITE = 2'd1,
        CFG_FINALIZE  = 2'd2,
        CFG_MAX_SIZE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BLKHDR  = 2'd1,
        PH_DATA    = 2'd2,
        PH_DECIDED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_FINALIZED  = 3'd0,
        ST_ALL_DONE   = 3'd1,
        ST_TOO_SHORT  = 3'd2,
        ST_NO_BLOCKS  = 3'd3,
        ST_HEADER_CUT = 3'd4,
        ST_DATA_CUT   = 3'd5,
        ST_OVERSIZE   = 3'd6
    } t_status;

    typedef struct packed {
        logic [15:0] append_code;
        logic [15:0] overwrite_code;
        logic [15:0] finalize_code;
        logic [16:0] max_size;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [16:0] total_size;
        logic        size_mismatch;
    } t_result;

endpackage

// ===== rtl/core/tbcs_stream_if.sv =====
// stream interfaces for input bytes and status results
interface tbcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface tbcs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [16:0] total_size;
    logic        size_mismatch;

    modport source (output valid, output status, output total_size, output size_mismatch,
                    input ready);
    modport sink   (input valid, input status, input total_size, input size_mismatch,
                    output ready);
endinterface

// ===== rtl/core/tlv_block_stream_checker.sv =====
// the status word is registered when the last byte is accepted and is valid in the next cycle
// throughput: one byte per cycle while ready is high; parse state advances on each accepted byte
// ready drops only while a status word waits in the output register unread
// a word taken in the cycle it is replaced costs no gap; an unread word stalls all bytes
// reset (synchronous): config back to defaults, parse state cleared, no sweep
module tlv_block_stream_checker import tbcs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [16:0]  i_cfg_data,
    tbcs_in_if.sink      i_in,
    tbcs_out_if.source   o_out
);

    t_cfg    r_cfg;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.append_code    <= 16'd1;
            r_cfg.overwrite_code <= 16'd2;
            r_cfg.finalize_code  <= 16'd3;
            r_cfg.max_size       <= SIZE_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_APPEND:    r_cfg.append_code    <= i_cfg_data[15:0];
                CFG_OVERWRITE: r_cfg.overwrite_code <= i_cfg_data[15:0];
                CFG_FINALIZE:  r_cfg.finalize_code  <= i_cfg_data[15:0];
                CFG_MAX_SIZE:  r_cfg.max_size       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tbcs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_acc),
        .i_byte  (i_in.payload_byte),
        .i_last  (i_in.last_byte),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last_byte) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.total_size    = r_out.total_size;
    assign o_out.size_mismatch = r_out.size_mismatch;

    a_word_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc && i_in.last_byte))
        else $error("status word without a last byte");

    a_mid_byte_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.last_byte && !r_out_valid) |=> !r_out_valid)
        else $error("status word on a non-last byte");

    a_mismatch_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_FINALIZED) |-> !r_out.size_mismatch)
        else $error("mismatch flag outside finalize");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.total_size <= SIZE_LIMIT))
        else $error("total size above limit");

endmodule

// ===== rtl/core/tbcs_parser.sv =====
// framing parser: per-byte state update and status decision
module tbcs_parser import tbcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  t_cfg        i_cfg,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_fcnt, n_fcnt;
    logic [15:0] r_blocks, n_blocks;
    logic [15:0] r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [16:0] r_running, n_running;
    logic [31:0] r_exp, n_exp;
    t_status     r_dec, n_dec;
    logic        r_mis, n_mis;

    logic        do_finish;
    logic [15:0] blocks_dec;
    logic [16:0] limit;
    logic [17:0] grown;
    t_status     status;

    assign limit      = (i_cfg.max_size > SIZE_LIMIT) ? SIZE_LIMIT : i_cfg.max_size;
    assign blocks_dec = r_blocks - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_fcnt    = r_fcnt;
        n_blocks  = r_blocks;
        n_type    = r_type;
        n_len     = r_len;
        n_seen    = r_seen;
        n_running = r_running;
        n_exp     = r_exp;
        n_dec     = r_dec;
        n_mis     = r_mis;
        do_finish = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                if (r_fcnt == 2'd0) begin
                    n_blocks = {i_byte, 8'h00};
                end else if (r_fcnt == 2'd1) begin
                    n_blocks = {r_blocks[15:8], i_byte};
                end
                if (r_fcnt == HDR_LAST) begin
                    n_fcnt = 2'd0;
                    if (r_blocks == 16'd0) begin
                        n_dec   = ST_NO_BLOCKS;
                        n_phase = PH_DECIDED;
                    end else begin
                        n_phase = PH_BLKHDR;
                    end
                end else begin
                    n_fcnt = r_fcnt + 2'd1;
                end
            end
            PH_BLKHDR: begin
                case (r_fcnt)
                    2'd0:    n_type = {i_byte, 8'h00};
                    2'd1:    n_type = {r_type[15:8], i_byte};
                    2'd2:    n_len  = {i_byte, 8'h00};
                    default: begin
                        n_len  = {r_len[15:8], i_byte};
                        n_seen = 16'd0;
                        n_exp  = 32'd0;
                    end
                endcase
                if (r_fcnt == HDR_LAST) begin
                    n_fcnt = 2'd0;
                    if (n_len == 16'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_fcnt = r_fcnt + 2'd1;
                end
            end
            PH_DATA: begin
                // only the first four data bytes form the expected size word
                if (r_seen < WORD_BYTES) begin
                    n_exp = {r_exp[23:0], i_byte};
                end
                n_seen = r_seen + 16'd1;
                if (n_seen >= r_len) begin
                    do_finish = 1'b1;
                end
            end
            default: ;
        endcase

        grown = {1'b0, r_running} + {2'b00, n_len};

        if (do_finish) begin
            if (r_type == i_cfg.append_code) begin
                if (grown > {1'b0, limit}) begin
                    n_dec   = ST_OVERSIZE;
                    n_phase = PH_DECIDED;
                end else begin
                    n_running = grown[16:0];
                    n_blocks  = blocks_dec;
                    n_phase   = (blocks_dec == 16'd0) ? PH_DECIDED : PH_BLKHDR;
                    if (blocks_dec == 16'd0) begin
                        n_dec = ST_ALL_DONE;
                    end
                end
            end else if (r_type != i_cfg.overwrite_code && r_type == i_cfg.finalize_code) begin
                if (n_len >= WORD_BYTES) begin
                    n_mis = (n_exp != {15'd0, r_running});
                end
                n_dec   = ST_FINALIZED;
                n_phase = PH_DECIDED;
            end else begin
                // overwrite and unknown blocks are skipped
                n_blocks = blocks_dec;
                n_phase  = (blocks_dec == 16'd0) ? PH_DECIDED : PH_BLKHDR;
                if (blocks_dec == 16'd0) begin
                    n_dec = ST_ALL_DONE;
                end
            end
        end

        case (n_phase)
            PH_DECIDED: status = n_dec;
            PH_HEADER:  status = ST_TOO_SHORT;
            PH_BLKHDR:  status = ST_HEADER_CUT;
            default:    status = ST_DATA_CUT;
        endcase

        o_res.status        = status;
        o_res.total_size    = n_running;
        o_res.size_mismatch = (status == ST_FINALIZED) ? n_mis : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase   <= PH_HEADER;
            r_fcnt    <= 2'd0;
            r_blocks  <= 16'd0;
            r_type    <= 16'd0;
            r_len     <= 16'd0;
            r_seen    <= 16'd0;
            r_running <= 17'd0;
            r_exp     <= 32'd0;
            r_dec     <= ST_FINALIZED;
            r_mis     <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_fcnt    <= n_fcnt;
            r_blocks  <= n_blocks;
            r_type    <= n_type;
            r_len     <= n_len;
            r_seen    <= n_seen;
            r_running <= n_running;
            r_exp     <= n_exp;
            r_dec     <= n_dec;
            r_mis     <= n_mis;
        end
    end

endmodule
